// ===== hdl/gbm_pkg.sv =====
// shared types and constants for the geometric brownian motion step unit
// no dependencies
`timescale 1ns / 1ps

package gbm_pkg;

    localparam int STEP_INDEX_BITS   = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int TAYLOR_TERMS      = 12;

    localparam logic [1:0] CFG_DRIFT       = 2'd0;
    localparam logic [1:0] CFG_VOLATILITY  = 2'd1;
    localparam logic [1:0] CFG_START_VALUE = 2'd2;

    localparam logic [31:0] START_VALUE_RST = 32'h0001_0000;

    // log2(e) and ln(2) in q.30
    localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    // 2048.0 and 24.0 in q.28
    localparam logic [39:0] DRIFT_CLAMP = 40'h80_0000_0000;
    localparam logic [32:0] EXP_CLAMP   = 33'h1_8000_0000;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    typedef struct packed {
        logic [STEP_INDEX_BITS-1:0] step_index;
        logic signed [31:0]         brownian_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] price;
        logic        overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] drift;
        logic [30:0]        volatility;
        logic [31:0]        start_value;
    } t_cfg;

    // exponent split into integer and fraction of a power of two
    typedef struct packed {
        logic signed [6:0] exp_int;
        logic [27:0]       exp_frac;
    } t_exp_item;

    typedef struct packed {
        logic [29:0]       z;
        logic signed [6:0] exp_int;
        logic [30:0]       sum;
        logic [30:0]       term;
        logic [29:0]       p;
        logic [29:0]       q0;
    } t_tay;

endpackage

// ===== hdl/gbm_front.sv =====
// front section: accepts transactions and forms the power-of-two exponent
// depends on gbm_pkg
`timescale 1ns / 1ps

module gbm_front import gbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_exp_valid,
    output t_exp_item o_exp_item,
    input  logic      i_exp_stall
);

    localparam int DPW = 34 + STEP_INDEX_BITS;
    localparam logic signed [41:0] EXP_HI = $signed({9'd0, EXP_CLAMP});
    localparam logic signed [41:0] EXP_LO = -EXP_HI;

    logic [5:0] r_v;
    logic       w_adv;

    logic [61:0]                r1_sq;
    logic [62:0]                r1_swm;
    logic                       r1_wneg;
    logic [STEP_INDEX_BITS-1:0] r1_t;

    logic [33:0]                r2_am;
    logic                       r2_aneg;
    logic [38:0]                r2_sm;
    logic                       r2_wneg;
    logic [STEP_INDEX_BITS-1:0] r2_t;

    logic [39:0] r3_dm;
    logic        r3_aneg;
    logic [38:0] r3_sm;
    logic        r3_wneg;

    logic [32:0] r4_em;
    logic        r4_eneg;

    logic [33:0] r5_ym;
    logic        r5_eneg;

    t_exp_item r6_exp;
    t_exp_item n_exp;

    logic [31:0]        w_wmag;
    logic [32:0]        w_hs;
    logic signed [34:0] w_a;
    logic               w_aneg;
    logic [33:0]        w_am;
    logic [38:0]        w_sm;
    logic [DPW-1:0]     w_dprod;
    logic [39:0]        w_dm;
    logic signed [41:0] w_dt;
    logic signed [41:0] w_st;
    logic signed [41:0] w_e;
    logic [32:0]        w_em;
    logic               w_eneg;
    logic [64:0]        w_yp;
    logic [5:0]         w_ip;
    logic [27:0]        w_fr;

    assign w_adv       = !r_v[5] || !i_exp_stall;
    assign o_in_stall  = !w_adv;
    assign o_exp_valid = r_v[5];
    assign o_exp_item  = r6_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[4:0], i_in_valid};
        end
    end

    // squares and diffusion product
    assign w_wmag = i_in_item.brownian_value[31] ? 32'(-i_in_item.brownian_value)
                                                 : 32'(i_in_item.brownian_value);

    // drift rate and rounded diffusion term
    assign w_hs   = 33'((r1_sq + 62'd268435456) >> 29);
    assign w_a    = 35'(i_cfg.drift) - $signed({2'b00, w_hs});
    assign w_aneg = w_a[34];
    assign w_am   = w_aneg ? 34'(-w_a) : 34'(w_a);
    assign w_sm   = 39'((64'(r1_swm) + 64'd8388608) >> 24);

    // drift over t, held at 2048.0
    assign w_dprod = DPW'(r2_am) * DPW'(r2_t);
    assign w_dm    = (w_dprod > DPW'(DRIFT_CLAMP)) ? DRIFT_CLAMP : w_dprod[39:0];

    // exponent sum with clamp
    assign w_dt = r3_aneg ? -$signed({2'b00, r3_dm}) : $signed({2'b00, r3_dm});
    assign w_st = r3_wneg ? -$signed({3'b000, r3_sm}) : $signed({3'b000, r3_sm});
    assign w_e  = w_dt + w_st;

    always_comb begin
        if (w_e > EXP_HI) begin
            w_em   = EXP_CLAMP;
            w_eneg = 1'b0;
        end else if (w_e < EXP_LO) begin
            w_em   = EXP_CLAMP;
            w_eneg = 1'b1;
        end else begin
            w_eneg = w_e[41];
            w_em   = w_e[41] ? 33'(-w_e) : 33'(w_e);
        end
    end

    // scale by log2(e)
    assign w_yp = 65'(r4_em) * 65'(LOG2E_Q30) + 65'd536870912;

    // integer and fraction split, fraction kept non-negative
    assign w_ip = r5_ym[33:28];
    assign w_fr = r5_ym[27:0];

    always_comb begin
        if (!r5_eneg) begin
            n_exp.exp_int  = $signed(7'(w_ip));
            n_exp.exp_frac = w_fr;
        end else if (w_fr == 28'd0) begin
            n_exp.exp_int  = -$signed(7'(w_ip));
            n_exp.exp_frac = 28'd0;
        end else begin
            n_exp.exp_int  = -($signed(7'(w_ip)) + 7'sd1);
            n_exp.exp_frac = 28'(29'h1000_0000 - {1'b0, w_fr});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sq   <= 62'(i_cfg.volatility) * 62'(i_cfg.volatility);
            r1_swm  <= 63'(i_cfg.volatility) * 63'(w_wmag);
            r1_wneg <= i_in_item.brownian_value[31];
            r1_t    <= i_in_item.step_index;

            r2_am   <= w_am;
            r2_aneg <= w_aneg;
            r2_sm   <= w_sm;
            r2_wneg <= r1_wneg;
            r2_t    <= r1_t;

            r3_dm   <= w_dm;
            r3_aneg <= r2_aneg;
            r3_sm   <= r2_sm;
            r3_wneg <= r2_wneg;

            r4_em   <= w_em;
            r4_eneg <= w_eneg;

            r5_ym   <= w_yp[63:30];
            r5_eneg <= r4_eneg;

            r6_exp  <= n_exp;
        end
    end

endmodule

// ===== hdl/gbm_queue.sv =====
// small queue between the front and back sections
// depends on gbm_pkg
`timescale 1ns / 1ps

module gbm_queue import gbm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    input  t_exp_item i_push_item,
    output logic      o_push_stall,
    output logic      o_pop_valid,
    output t_exp_item o_pop_item,
    input  logic      i_pop_stall
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_exp_item     r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_stall = (r_count == CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

// ===== hdl/gbm_back.sv =====
// back section: 2^f series, start value scaling, shift, rounding, saturation
// depends on gbm_pkg
`timescale 1ns / 1ps

module gbm_back import gbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_exp_valid,
    input  t_exp_item i_exp_item,
    output logic      o_exp_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int NTS = 3 * TAYLOR_TERMS;
    localparam int NB  = NTS + 4;

    localparam logic [1:0] SH_LEFT  = 2'd0;
    localparam logic [1:0] SH_RIGHT = 2'd1;
    localparam logic [1:0] SH_ZERO  = 2'd2;

    logic [NB-1:0] r_v;
    logic          w_adv;

    t_tay r_st [NTS+1];
    t_tay n_st0;

    logic [57:0] w_zp;

    logic [62:0]       r_prod;
    logic signed [6:0] r_pn;

    logic [1:0]  r_mode;
    logic [63:0] r_rval;
    logic [5:0]  r_rsh;
    logic [1:0]  n_mode;
    logic [63:0] n_rval;
    logic [5:0]  n_rsh;
    logic signed [7:0] w_s;

    t_out_item   r_out;
    t_out_item   n_out;
    logic [63:0] w_lim;
    logic [63:0] w_lsh;
    logic [63:0] w_rsh;

    assign w_adv       = !r_v[NB-1] || !i_out_stall;
    assign o_exp_stall = !w_adv;
    assign o_out_valid = r_v[NB-1];
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NB-2:0], i_exp_valid};
        end
    end

    // f*ln2 and series seed
    assign w_zp = 58'(i_exp_item.exp_frac) * 58'(LN2_Q30);

    always_comb begin
        n_st0.z       = w_zp[57:28];
        n_st0.exp_int = i_exp_item.exp_int;
        n_st0.sum     = ONE_Q30;
        n_st0.term    = ONE_Q30;
        n_st0.p       = '0;
        n_st0.q0      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= n_st0;
        end
    end

    // three stages per term: multiply by z, reciprocal multiply, quotient fix
    for (genvar j = 1; j <= NTS; j++) begin : g_tay
        localparam int SUB = (j - 1) % 3;
        localparam int K   = (j - 1) / 3 + 1;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

        t_tay n_st;

        if (SUB == 0) begin : g_mul
            logic [60:0] w_mp;
            assign w_mp = 61'(r_st[j-1].term) * 61'(r_st[j-1].z);
            always_comb begin
                n_st   = r_st[j-1];
                n_st.p = w_mp[59:30];
            end
        end else if (SUB == 1) begin : g_rcp
            logic [62:0] w_dp;
            assign w_dp = 63'(r_st[j-1].p) * 63'(RECIP);
            always_comb begin
                n_st    = r_st[j-1];
                n_st.q0 = w_dp[61:32];
            end
        end else begin : g_fix
            logic [30:0] w_rem;
            logic [30:0] w_q;
            assign w_rem = 31'(r_st[j-1].p) - 31'(r_st[j-1].q0) * 31'(K);
            assign w_q   = 31'(r_st[j-1].q0) + ((w_rem >= 31'(K)) ? 31'd1 : 31'd0);
            always_comb begin
                n_st      = r_st[j-1];
                n_st.term = w_q;
                n_st.sum  = r_st[j-1].sum + w_q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[j] <= n_st;
            end
        end
    end

    // rounding setup from the shift distance 30 - n
    assign w_s = 8'sd30 - 8'(r_pn);

    always_comb begin
        if (w_s <= 8'sd0) begin
            n_mode = SH_LEFT;
            n_rval = 64'(r_prod);
            n_rsh  = 6'(-w_s);
        end else if (w_s >= 8'sd64) begin
            n_mode = SH_ZERO;
            n_rval = 64'(r_prod);
            n_rsh  = '0;
        end else begin
            n_mode = SH_RIGHT;
            n_rval = 64'(r_prod) + (64'd1 << (6'(w_s) - 6'd1));
            n_rsh  = 6'(w_s);
        end
    end

    assign w_lim = 64'(32'hFFFF_FFFF >> r_rsh[2:0]);
    assign w_lsh = r_rval << r_rsh[2:0];
    assign w_rsh = r_rval >> r_rsh;

    always_comb begin
        n_out = '0;
        case (r_mode)
            SH_LEFT: begin
                if (r_rval > w_lim) begin
                    n_out.price    = 32'hFFFF_FFFF;
                    n_out.overflow = 1'b1;
                end else begin
                    n_out.price = w_lsh[31:0];
                end
            end
            SH_RIGHT: begin
                if (w_rsh[63:32] != 32'd0) begin
                    n_out.price    = 32'hFFFF_FFFF;
                    n_out.overflow = 1'b1;
                end else begin
                    n_out.price = w_rsh[31:0];
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= 63'(i_cfg.start_value) * 63'(r_st[NTS].sum);
            r_pn   <= r_st[NTS].exp_int;
            r_mode <= n_mode;
            r_rval <= n_rval;
            r_rsh  <= n_rsh;
            r_out  <= n_out;
        end
    end

`ifndef SYNTH
    a_ovf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow |-> o_out_item.price == 32'hFFFF_FFFF)
        else $error("overflow without saturated price");

    a_series_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NTS] |-> r_st[NTS].sum[30])
        else $error("2^f series below one");
`endif

endmodule

// ===== hdl/gbm_exact_step_unit.sv =====
// top level of the geometric brownian motion exact step unit
// depends on gbm_pkg, gbm_front, gbm_queue, gbm_back
`timescale 1ns / 1ps

// Each transaction (step index t, brownian value w) yields one result
// x0*exp((mu - sigma^2/2)*t + sigma*w) in unsigned Q16.16, saturated with an
// overflow flag. One transaction is taken per cycle while o_in_stall is low,
// and results leave at one per cycle while i_out_stall is low. Most of the
// pipeline is the twelve-term 2^f series, three pipeline stages per term.
// The front section (6 stages) and the back section (40 stages) stall on
// their own, with a small queue between them. Configuration writes take
// effect on the next cycle and belong only to times when no transaction is
// in flight. There is no clearing pass after reset.

module gbm_exact_step_unit import gbm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item,
    input  logic       i_out_stall
);

    t_cfg      r_cfg;
    logic      w_fq_valid;
    t_exp_item w_fq_item;
    logic      w_fq_stall;
    logic      w_qb_valid;
    t_exp_item w_qb_item;
    logic      w_qb_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift       <= '0;
            r_cfg.volatility  <= '0;
            r_cfg.start_value <= START_VALUE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DRIFT:       r_cfg.drift       <= $signed(i_cfg_data);
                CFG_VOLATILITY:  r_cfg.volatility  <= i_cfg_data[30:0];
                CFG_START_VALUE: r_cfg.start_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_exp_valid (w_fq_valid),
        .o_exp_item  (w_fq_item),
        .i_exp_stall (w_fq_stall)
    );

    gbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .i_push_item  (w_fq_item),
        .o_push_stall (w_fq_stall),
        .o_pop_valid  (w_qb_valid),
        .o_pop_item   (w_qb_item),
        .i_pop_stall  (w_qb_stall)
    );

    gbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_exp_valid (w_qb_valid),
        .i_exp_item  (w_qb_item),
        .o_exp_stall (w_qb_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for gbm_exact_step_unit: random and directed transactions
// with a bit-exact price predictor, random input gaps and random output stalls
// depends on gbm_pkg and the gbm_exact_step_unit rtl
`timescale 1ns / 1ps

module testbench;
    import gbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;

    t_in_item    pending_steps[$];
    t_out_item   expected_prices[$];
    logic [63:0] cur_drift;
    logic [63:0] cur_vol;
    logic [63:0] cur_x0;
    int          mismatches;
    int          idle_cycles;
    int          send_gap;
    int          stall_len;
    bit          feeding;

    gbm_exact_step_unit dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_out_item predict_price(t_in_item it);
        t_out_item   res;
        logic [63:0] t, sg, x0, hs, am, dm, wm, sm, em, ym, f, z, sum, term, prod, r;
        longint      mu, w, a, dterm, sterm, e, n, s;
        t = 64'(it.step_index);
        w = longint'(it.brownian_value);
        mu = longint'($signed(cur_drift[31:0]));
        sg = cur_vol & 64'h7FFF_FFFF;
        x0 = cur_x0 & 64'hFFFF_FFFF;
        hs = (sg * sg + (64'd1 << 28)) >> 29;
        a = mu - longint'(hs);
        am = a < 0 ? -a : a;
        if (t != 0 && am > (64'h80_0000_0000 / t)) dm = 64'h80_0000_0000;
        else dm = am * t;
        dterm = a < 0 ? -longint'(dm) : longint'(dm);
        wm = w < 0 ? -w : w;
        sm = (sg * wm + (64'd1 << 23)) >> 24;
        sterm = w < 0 ? -longint'(sm) : longint'(sm);
        e = dterm + sterm;
        if (e > (longint'(24) << 28)) e = longint'(24) << 28;
        if (e < -(longint'(24) << 28)) e = -(longint'(24) << 28);
        em = e < 0 ? -e : e;
        ym = (em * 64'd1549082005 + (64'd1 << 29)) >> 30;
        if (e < 0) begin
            n = -longint'((ym + (64'd1 << 28) - 1) >> 28);
            f = 64'(-longint'(ym) - n * (longint'(1) << 28));
        end else begin
            n = longint'(ym >> 28);
            f = ym & ((64'd1 << 28) - 1);
        end
        z = (f * 64'd744261118) >> 28;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * z) >> 30) / k;
            sum += term;
        end
        prod = x0 * sum;
        s = 30 - n;
        res.overflow = 1'b0;
        if (s <= 0) begin
            if (prod > (64'hFFFF_FFFF >> (-s))) begin
                r = 64'hFFFF_FFFF;
                res.overflow = 1'b1;
            end else begin
                r = prod << (-s);
            end
        end else if (s >= 64) begin
            r = 0;
        end else begin
            r = (prod + (64'd1 << (s - 1))) >> s;
            if (r > 64'hFFFF_FFFF) begin
                r = 64'hFFFF_FFFF;
                res.overflow = 1'b1;
            end
        end
        res.price = r[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_DRIFT) cur_drift = 64'(val);
        else if (idx == CFG_VOLATILITY) cur_vol = 64'(val[30:0]);
        else if (idx == CFG_START_VALUE) cur_x0 = 64'(val);
    endtask

    task automatic wait_idle();
        while (pending_steps.size() != 0 || expected_prices.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_step(bit wide);
        t_in_item it;
        int r;
        r = $urandom_range(0, 9);
        it.step_index = wide ? 16'($urandom) : 16'($urandom_range(0, 200));
        if (r < 6) it.brownian_value = $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
        else it.brownian_value = $urandom;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            expected_prices.push_back(predict_price(i_in_item));
            if (pending_steps.size() != 0 && feeding && pick_gap() == 0) begin
                i_in_item <= pending_steps.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                send_gap   <= pick_gap();
            end
        end else if (!i_in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_steps.size() != 0 && feeding) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_steps.pop_front();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_len   <= 0;
        end else begin
            if (stall_len > 0) begin
                stall_len   <= stall_len - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_len   <= pick_gap();
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_prices.size() == 0) begin
                    report_mismatch("unexpected transaction", o_out_item.price, 32'h0);
                end else begin
                    t_out_item want;
                    want = expected_prices.pop_front();
                    if (o_out_item.price !== want.price)
                        report_mismatch("price", o_out_item.price, want.price);
                    if (o_out_item.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(o_out_item.overflow),
                                        32'(want.overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || !feeding)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        logic [31:0] drifts[6];
        logic [31:0] vols[6];
        logic [31:0] starts[6];
        mismatches  = 0;
        feeding     = 1'b0;
        cur_drift   = 0;
        cur_vol     = 0;
        cur_x0      = 64'(START_VALUE_RST);
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DRIFT;
        i_cfg_data  = 32'h0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, extremes of both fields
        feeding = 1'b1;
        it.step_index = 16'h0000; it.brownian_value = 32'sh0000_0000; pending_steps.push_back(it);
        it.step_index = 16'hFFFF; it.brownian_value = 32'sh7FFF_FFFF; pending_steps.push_back(it);
        it.step_index = 16'hFFFF; it.brownian_value = 32'sh8000_0000; pending_steps.push_back(it);
        wait_idle();
        feeding = 1'b0;
        write_reg(CFG_DRIFT, 32'h0400_0000);
        write_reg(CFG_VOLATILITY, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        feeding = 1'b1;
        foreach (drifts[i]) begin
            it.step_index = 16'(i * 3); it.brownian_value = $signed(32'(i << 22));
            pending_steps.push_back(it);
        end
        it.step_index = 16'hFFFF; it.brownian_value = 32'sh7FFF_FFFF; pending_steps.push_back(it);
        it.step_index = 16'h0001; it.brownian_value = 32'sh8000_0000; pending_steps.push_back(it);
        wait_idle();
        feeding = 1'b0;
        write_reg(CFG_START_VALUE, 32'h0);
        feeding = 1'b1;
        it.step_index = 16'd5; it.brownian_value = 32'sh0100_0000; pending_steps.push_back(it);
        wait_idle();

        drifts = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0080_0000, 32'hFF80_0000,
                   32'h0000_1000};
        vols   = '{32'h0, 32'h7FFF_FFFF, 32'h1000_0000, 32'h0400_0000, 32'h0100_0000,
                   32'h0800_0000};
        starts = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0064_0000,
                   32'h8000_0000, 32'h0000_0000};
        for (int ph = 0; ph < 12; ph++) begin
            feeding = 1'b0;
            if (ph < 6) begin
                write_reg(CFG_DRIFT, drifts[ph]);
                write_reg(CFG_VOLATILITY, vols[ph]);
                write_reg(CFG_START_VALUE, starts[ph]);
            end else begin
                write_reg(CFG_DRIFT, $urandom_range(0, 1) ? $urandom
                                     : 32'($signed(32'($urandom_range(0, 1 << 24)) - (1 << 23))));
                write_reg(CFG_VOLATILITY, $urandom_range(0, 1) ? $urandom
                                          : 32'($urandom_range(0, 1 << 27)));
                write_reg(CFG_START_VALUE, $urandom);
            end
            feeding = 1'b1;
            for (int i = 0; i < 85; i++)
                pending_steps.push_back(rand_step($urandom_range(0, 4) == 0));
            wait_idle();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
